@@ design/edf_pkg.sv @@
package edf_pkg;

    // Default table depth and register reset value
    localparam int          CAPACITY_DEF    = 16;
    localparam logic [31:0] RETENTION_RESET = 32'd60000;

    // One input item
    typedef struct packed {
        logic [31:0] sender_tag;
        logic [31:0] epoch_tag;
        logic [31:0] msg_tag;
        logic [63:0] now_time;
    } item_t;

    // One result item
    typedef struct packed {
        logic        error_code;
        logic        is_duplicate;
        logic        evicted;
        logic [4:0]  active_entries;
        logic [31:0] accepted_total;
        logic [31:0] duplicate_total;
        logic [31:0] eviction_total;
    } result_t;

    // One table entry as held in the slot memory
    typedef struct packed {
        logic [31:0] sender_tag;
        logic [31:0] epoch_tag;
        logic [31:0] msg_tag;
        logic [63:0] expiry;
    } slot_t;

    // Sequencer to scan unit
    typedef struct packed {
        logic clear;
        logic eval_en;
    } scan_ctrl_t;

    // Scan unit to sequencer
    typedef struct packed {
        logic hit;
        logic free_found;
    } scan_flags_t;

endpackage

@@ design/expiring_duplicate_filter_top.sv @@
// Channel   Direction  Handshake                      Payload
// item      in         item_valid / item_stall        item_t   (key and time)
// result    out        result_valid / result_stall    result_t (flags, counts)
// config    in         retention_wr_en                retention_wr_data (32 bits)
//
// An item is taken in the idle state; the scan state then streams every slot out of
// the slot memory's single read port through the compare unit, and the write-back
// state writes back the entry and posts the result.
// Reset clears the valid bits, the counters and the sequencer; slot contents stay
// undefined until written. A stalled result holds the write-back cycle.
module expiring_duplicate_filter_top
    import edf_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        retention_wr_en,
    input  logic [31:0] retention_wr_data,
    input  logic        item_valid,
    output logic        item_stall,
    input  item_t       item,
    output logic        result_valid,
    input  logic        result_stall,
    output result_t     result
);

    localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW    = $clog2(CAPACITY + 1);
    localparam int ACT_W = ($clog2(CAPACITY + 2) > 5) ? $clog2(CAPACITY + 2) : 5;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_WRITE = 2'd2;

    logic [1:0]       state_reg;
    logic [1:0]       state_next;
    logic [31:0]      retention_reg;
    item_t            item_reg;
    logic             err_reg;
    logic [CW-1:0]    scan_cnt_reg;
    logic             eval_en_reg;
    logic [AW-1:0]    eval_idx_reg;
    logic [CAPACITY-1:0] valid_reg;
    logic [31:0]      accepted_reg;
    logic [31:0]      duplicate_reg;
    logic [31:0]      eviction_reg;
    logic             result_valid_reg;
    result_t          result_reg;

    logic             accept;
    logic             rd_en;
    logic [AW-1:0]    rd_addr;
    slot_t            rd_data;
    slot_t            wr_data;
    logic             go;
    logic             insert;
    logic             evict;
    logic [AW-1:0]    target;
    logic [64:0]      exp_sum;
    logic [63:0]      new_expiry;
    logic [ACT_W-1:0] active_final;
    logic             live;
    scan_ctrl_t       scan_ctrl;
    scan_flags_t      scan_flags;
    logic [AW-1:0]    free_idx;
    logic [AW-1:0]    min_idx;
    logic [ACT_W-1:0] active_cnt;
    result_t          result_next;

    // Input handshake
    assign item_stall = (state_reg != ST_IDLE);
    assign accept     = item_valid && !item_stall;

    // Scan address sequencing
    assign rd_en   = (state_reg == ST_SCAN) && (scan_cnt_reg < CW'(CAPACITY));
    assign rd_addr = scan_cnt_reg[AW-1:0];

    assign scan_ctrl.clear   = accept;
    assign scan_ctrl.eval_en = eval_en_reg;

    // Write-back decisions
    assign go      = (state_reg == ST_WRITE) && (!result_valid_reg || !result_stall);
    assign insert  = !err_reg && !scan_flags.hit;
    assign evict   = insert && !scan_flags.free_found;
    assign target  = scan_flags.free_found ? free_idx : min_idx;
    assign exp_sum = {1'b0, item_reg.now_time} + {33'b0, retention_reg};
    assign new_expiry = exp_sum[64] ? '1 : exp_sum[63:0];

    assign wr_data.sender_tag = item_reg.sender_tag;
    assign wr_data.epoch_tag  = item_reg.epoch_tag;
    assign wr_data.msg_tag    = item_reg.msg_tag;
    assign wr_data.expiry     = new_expiry;

    // New entry is live unless its saturated expiry equals now
    assign active_final = active_cnt
                          + ACT_W'(insert && !(&item_reg.now_time))
                          - ACT_W'(evict);

    always_comb
    begin
        result_next.error_code      = err_reg;
        result_next.is_duplicate    = !err_reg && scan_flags.hit;
        result_next.evicted         = evict;
        result_next.active_entries  = active_final[4:0];
        result_next.accepted_total  = accepted_reg + 32'(insert);
        result_next.duplicate_total = duplicate_reg + 32'(result_next.is_duplicate);
        result_next.eviction_total  = eviction_reg + 32'(evict);
    end

    // Sequencer
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_cnt_reg == CW'(CAPACITY))
                begin
                    state_next = ST_WRITE;
                end
            end
            ST_WRITE:
            begin
                if (go)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            retention_reg    <= RETENTION_RESET;
            scan_cnt_reg     <= '0;
            eval_en_reg      <= 1'b0;
            valid_reg        <= '0;
            accepted_reg     <= '0;
            duplicate_reg    <= '0;
            eviction_reg     <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            eval_en_reg <= rd_en;

            if (retention_wr_en)
            begin
                retention_reg <= retention_wr_data;
            end

            if (accept)
            begin
                scan_cnt_reg <= '0;
            end
            else if (state_reg == ST_SCAN)
            begin
                scan_cnt_reg <= scan_cnt_reg + CW'(1);
            end

            // Purge an expired slot as it passes the compare unit
            if (eval_en_reg && !err_reg && !live)
            begin
                valid_reg[eval_idx_reg] <= 1'b0;
            end

            if (go)
            begin
                if (insert)
                begin
                    valid_reg[target] <= 1'b1;
                end
                accepted_reg  <= result_next.accepted_total;
                duplicate_reg <= result_next.duplicate_total;
                eviction_reg  <= result_next.eviction_total;
            end

            // Output register
            if (go)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        eval_idx_reg <= rd_addr;
        if (accept)
        begin
            item_reg <= item;
            err_reg  <= (item.sender_tag == 32'd0) || (item.epoch_tag == 32'd0)
                        || (item.msg_tag == 32'd0) || (retention_reg == 32'd0);
        end
        if (go)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    edf_slot_store #(
        .CAPACITY (CAPACITY)
    ) u_slot_store (
        .clk     (clk),
        .wr_en   (go && insert),
        .wr_addr (target),
        .wr_data (wr_data),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    edf_scan_unit #(
        .CAPACITY (CAPACITY)
    ) u_scan_unit (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (scan_ctrl),
        .eval_idx   (eval_idx_reg),
        .slot_valid (valid_reg[eval_idx_reg]),
        .slot       (rd_data),
        .key        (item_reg),
        .live       (live),
        .flags      (scan_flags),
        .free_idx   (free_idx),
        .min_idx    (min_idx),
        .active_cnt (active_cnt)
    );

endmodule

@@ design/edf_slot_store.sv @@
module edf_slot_store
    import edf_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic                                        clk,
    input  logic                                        wr_en,
    input  logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] wr_addr,
    input  slot_t                                       wr_data,
    input  logic                                        rd_en,
    input  logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] rd_addr,
    output slot_t                                       rd_data
);

    slot_t mem [CAPACITY];
    slot_t rd_data_reg;

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ design/edf_scan_unit.sv @@
module edf_scan_unit
    import edf_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)
(
    input  logic                                        clk,
    input  logic                                        rst_n,
    input  scan_ctrl_t                                  ctrl,
    input  logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] eval_idx,
    input  logic                                        slot_valid,
    input  slot_t                                       slot,
    input  item_t                                       key,
    output logic                                        live,
    output scan_flags_t                                 flags,
    output logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] free_idx,
    output logic [((CAPACITY > 1) ? $clog2(CAPACITY) : 1)-1:0] min_idx,
    output logic [(($clog2(CAPACITY + 2) > 5) ? $clog2(CAPACITY + 2) : 5)-1:0] active_cnt
);

    localparam int AW    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int ACT_W = ($clog2(CAPACITY + 2) > 5) ? $clog2(CAPACITY + 2) : 5;

    logic             match;
    logic             earlier;
    logic             hit_reg;
    logic             free_found_reg;
    logic             min_first_reg;
    logic [ACT_W-1:0] active_reg;
    logic [AW-1:0]    free_idx_reg;
    logic [AW-1:0]    min_idx_reg;
    logic [63:0]      min_exp_reg;

    // Shared compare unit: expiry check, key match, earliest expiry
    assign live    = slot_valid && (key.now_time < slot.expiry);
    assign match   = live
                     && (slot.sender_tag == key.sender_tag)
                     && (slot.epoch_tag  == key.epoch_tag)
                     && (slot.msg_tag    == key.msg_tag);
    assign earlier = min_first_reg || (slot.expiry < min_exp_reg);

    // Accumulated control flags and live count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hit_reg        <= 1'b0;
            free_found_reg <= 1'b0;
            min_first_reg  <= 1'b1;
            active_reg     <= '0;
        end
        else if (ctrl.clear)
        begin
            hit_reg        <= 1'b0;
            free_found_reg <= 1'b0;
            min_first_reg  <= 1'b1;
            active_reg     <= '0;
        end
        else if (ctrl.eval_en)
        begin
            if (match)
            begin
                hit_reg <= 1'b1;
            end
            if (!live)
            begin
                free_found_reg <= 1'b1;
            end
            if (live)
            begin
                active_reg <= active_reg + ACT_W'(1);
            end
            min_first_reg <= 1'b0;
        end
    end

    // First free slot and earliest expiry (strict compare keeps lowest index)
    always_ff @(posedge clk)
    begin
        if (ctrl.eval_en && !ctrl.clear)
        begin
            if (!live && !free_found_reg)
            begin
                free_idx_reg <= eval_idx;
            end
            if (earlier)
            begin
                min_exp_reg <= slot.expiry;
                min_idx_reg <= eval_idx;
            end
        end
    end

    assign flags.hit        = hit_reg;
    assign flags.free_found = free_found_reg;
    assign free_idx         = free_idx_reg;
    assign min_idx          = min_idx_reg;
    assign active_cnt       = active_reg;

endmodule

@@ verif/expiring_duplicate_filter_top_test.sv @@
`timescale 1ns / 1ps

module expiring_duplicate_filter_top_test;
    import edf_pkg::*;

    localparam int          DEPTH       = CAPACITY_DEF;
    localparam logic [63:0] TIME_TOP    = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [31:0] WORD_TOP    = 32'hFFFF_FFFF;
    localparam int          SETTLE_CYC  = 3 * (CAPACITY_DEF + 3);
    localparam int          MAX_REPORTS = 10;

    // One row of the directed plan
    typedef struct {
        bit          set_keep;
        logic [31:0] keep;
        item_t       it;
        bit          typed;
        result_t     want;
    } plan_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        retention_wr_en = 1'b0;
    logic [31:0] retention_wr_data = '0;
    logic        item_valid = 1'b0;
    logic        item_stall;
    item_t       item = '0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    result_t     result;

    // Typed expectation travelling with the item being offered
    bit          typed_on = 1'b0;
    result_t     typed_outcome = '0;

    // Shadow of the key table, counters and register
    bit          held_valid [DEPTH];
    bit [31:0]   held_alias [DEPTH];
    bit [31:0]   held_epoch [DEPTH];
    bit [31:0]   held_msg [DEPTH];
    bit [63:0]   held_expiry [DEPTH];
    bit [31:0]   tally_accepted = '0;
    bit [31:0]   tally_dup = '0;
    bit [31:0]   tally_evict = '0;
    logic [31:0] keep_cfg = RETENTION_RESET;

    result_t     outcome_q [$];
    int          mismatches = 0;

    // Random stimulus state
    bit          sender_calm = 1'b0;
    bit [31:0]   alias_pool [3];
    bit [31:0]   epoch_pool [2];
    bit [31:0]   msg_pool [5];
    logic [63:0] clock_now = '0;

    expiring_duplicate_filter_top dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .retention_wr_en   (retention_wr_en),
        .retention_wr_data (retention_wr_data),
        .item_valid        (item_valid),
        .item_stall        (item_stall),
        .item              (item),
        .result_valid      (result_valid),
        .result_stall      (result_stall),
        .result            (result)
    );

    always #6 clk = ~clk;

    // Outcome of one key lookup; updates the shadow table
    function automatic result_t predict_outcome(input item_t it);
        result_t     r;
        int          hit;
        int          slot;
        int          live;
        logic [64:0] sum;
        r = '0;
        hit = -1;
        slot = -1;
        if (it.sender_tag == 0 || it.epoch_tag == 0 || it.msg_tag == 0 ||
            keep_cfg == 0)
            r.error_code = 1'b1;
        else
        begin
            // purge expired entries first
            for (int i = 0; i < DEPTH; i++)
                if (held_valid[i] && it.now_time >= held_expiry[i])
                    held_valid[i] = 1'b0;
            for (int i = 0; i < DEPTH; i++)
                if (hit < 0 && held_valid[i] && held_alias[i] == it.sender_tag &&
                    held_epoch[i] == it.epoch_tag && held_msg[i] == it.msg_tag)
                    hit = i;
            if (hit >= 0)
            begin
                r.is_duplicate = 1'b1;
                tally_dup++;
            end
            else
            begin
                for (int i = 0; i < DEPTH; i++)
                    if (slot < 0 && !held_valid[i])
                        slot = i;
                // full: earliest expiry goes, lowest index on ties
                if (slot < 0)
                begin
                    slot = 0;
                    for (int i = 1; i < DEPTH; i++)
                        if (held_expiry[i] < held_expiry[slot])
                            slot = i;
                    r.evicted = 1'b1;
                    tally_evict++;
                end
                sum = {1'b0, it.now_time} + {33'b0, keep_cfg};
                held_valid[slot]  = 1'b1;
                held_alias[slot]  = it.sender_tag;
                held_epoch[slot]  = it.epoch_tag;
                held_msg[slot]    = it.msg_tag;
                held_expiry[slot] = sum[64] ? TIME_TOP : sum[63:0];
                tally_accepted++;
            end
        end
        live = 0;
        for (int i = 0; i < DEPTH; i++)
            if (held_valid[i] && it.now_time < held_expiry[i])
                live++;
        r.active_entries  = live[4:0];
        r.accepted_total  = tally_accepted;
        r.duplicate_total = tally_dup;
        r.eviction_total  = tally_evict;
        return r;
    endfunction

    function automatic item_t key_at(input logic [31:0] a, input logic [31:0] e,
                                     input logic [31:0] m, input logic [63:0] now);
        item_t it;
        it.sender_tag = a;
        it.epoch_tag  = e;
        it.msg_tag    = m;
        it.now_time   = now;
        return it;
    endfunction

    function automatic result_t outcome(input bit err, input bit dup, input bit ev,
                                        input int act, input int acc, input int dupt,
                                        input int evt);
        result_t r;
        r.error_code      = err;
        r.is_duplicate    = dup;
        r.evicted         = ev;
        r.active_entries  = act[4:0];
        r.accepted_total  = acc;
        r.duplicate_total = dupt;
        r.eviction_total  = evt;
        return r;
    endfunction

    function automatic plan_row_t make_row(input bit set_keep, input logic [31:0] keep,
                                           input item_t it, input bit typed,
                                           input result_t want);
        plan_row_t row;
        row.set_keep = set_keep;
        row.keep     = keep;
        row.it       = it;
        row.typed    = typed;
        row.want     = want;
        return row;
    endfunction

    function automatic bit [31:0] nonzero_word();
        bit [31:0] v;
        v = $urandom;
        return (v == 0) ? 32'd1 : v;
    endfunction

    // Mostly well-formed keys from a small pool, with some noise
    function automatic item_t random_item();
        item_t       it;
        int          r;
        int unsigned cap;
        r = $urandom_range(0, 99);
        it.sender_tag = alias_pool[$urandom_range(0, 2)];
        it.epoch_tag  = epoch_pool[$urandom_range(0, 1)];
        it.msg_tag    = msg_pool[$urandom_range(0, 4)];
        cap = keep_cfg >> 3;
        if (cap == 0)
            cap = 1;
        if ($urandom_range(0, 9) == 0)
            clock_now += {32'b0, keep_cfg} + $urandom_range(0, 2);
        else
            clock_now += $urandom_range(0, cap);
        it.now_time = clock_now;
        if (r < 6)
        begin
            case ($urandom_range(0, 3))
                0: it.sender_tag = '0;
                1: it.epoch_tag = '0;
                2: it.msg_tag = '0;
                default: it = key_at('0, '0, '0, it.now_time);
            endcase
        end
        else if (r < 13)
            it = key_at($urandom, $urandom, $urandom, it.now_time);
        else if (r < 17)
            it.now_time = {$urandom, $urandom};
        else if (r < 20)
            it.now_time = TIME_TOP - $urandom_range(0, 3);
        return it;
    endfunction

    function automatic int pick_gap();
        int r;
        if (sender_calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 45)
            return 0;
        if (r < 88)
            return $urandom_range(1, 6);
        if (r < 97)
            return $urandom_range(7, 25);
        return $urandom_range(26, 70);
    endfunction

    task automatic note_mismatch(input string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS)
            $display("%0t: mismatch: %s", $realtime, msg);
    endtask

    task automatic check_outcome(input result_t want, input result_t got);
        if (got.error_code !== want.error_code)
            note_mismatch($sformatf("error_code expected %0h got %0h",
                                    want.error_code, got.error_code));
        if (got.is_duplicate !== want.is_duplicate)
            note_mismatch($sformatf("is_duplicate expected %0h got %0h",
                                    want.is_duplicate, got.is_duplicate));
        if (got.evicted !== want.evicted)
            note_mismatch($sformatf("evicted expected %0h got %0h",
                                    want.evicted, got.evicted));
        if (got.active_entries !== want.active_entries)
            note_mismatch($sformatf("active_entries expected %0d got %0d",
                                    want.active_entries, got.active_entries));
        if (got.accepted_total !== want.accepted_total)
            note_mismatch($sformatf("accepted_total expected %0d got %0d",
                                    want.accepted_total, got.accepted_total));
        if (got.duplicate_total !== want.duplicate_total)
            note_mismatch($sformatf("duplicate_total expected %0d got %0d",
                                    want.duplicate_total, got.duplicate_total));
        if (got.eviction_total !== want.eviction_total)
            note_mismatch($sformatf("eviction_total expected %0d got %0d",
                                    want.eviction_total, got.eviction_total));
    endtask

    // Offer one item from the falling edge; return once the transfer is taken
    task automatic send_item(input item_t it, input bit typed, input result_t want);
        @(negedge clk);
        item_valid    <= 1'b1;
        item          <= it;
        typed_on      <= typed;
        typed_outcome <= want;
        do
            @(posedge clk);
        while (item_stall);
    endtask

    task automatic pause_sender(input int n);
        if (n > 0)
        begin
            @(negedge clk);
            item_valid <= 1'b0;
            repeat (n - 1) @(negedge clk);
        end
    endtask

    // Hold off the sender until every outstanding result is back
    task automatic drain_results();
        @(negedge clk);
        item_valid <= 1'b0;
        while (outcome_q.size() != 0)
            @(negedge clk);
    endtask

    task automatic set_retention(input logic [31:0] v);
        drain_results();
        repeat (SETTLE_CYC) @(negedge clk);
        retention_wr_en   <= 1'b1;
        retention_wr_data <= v;
        @(negedge clk);
        retention_wr_en <= 1'b0;
        keep_cfg = v;
    endtask

    // Predict on each item transfer, check each result transfer
    always @(posedge clk)
    begin : watch_transfers
        result_t want;
        if (rst_n)
        begin
            if (item_valid && !item_stall)
            begin
                want = predict_outcome(item);
                outcome_q.push_back(typed_on ? typed_outcome : want);
            end
            if (result_valid && !result_stall)
            begin
                if (outcome_q.size() == 0)
                    note_mismatch($sformatf("result %h with none expected", result));
                else
                    check_outcome(outcome_q.pop_front(), result);
            end
        end
    end

    // Receiver back-pressure: quiet stretches, then mostly short stalls
    initial
    begin : receiver_pace
        int hold;
        int stretch;
        int r;
        bit quiet;
        hold = 0;
        stretch = 0;
        quiet = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stretch == 0)
            begin
                quiet = ($urandom_range(0, 3) == 0);
                stretch = $urandom_range(50, 400);
            end
            stretch--;
            if (hold == 0 && !quiet)
            begin
                r = $urandom_range(0, 99);
                if (r < 12)
                    hold = $urandom_range(1, 4);
                else if (r < 16)
                    hold = $urandom_range(5, 20);
                else if (r < 17)
                    hold = $urandom_range(21, 80);
            end
            result_stall <= (hold != 0);
            if (hold != 0)
                hold--;
        end
    end

    initial
    begin : stimulus
        plan_row_t   plan [$];
        logic [31:0] phase_keep [6];
        int          phase_len [6];
        result_t     none;
        none = '0;

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        // directed: invalid keys, accept, duplicate, extremes, expiry at time top
        plan.push_back(make_row(0, '0, key_at('0, 5, 5, 0), 1, outcome(1, 0, 0, 0, 0, 0, 0)));
        plan.push_back(make_row(0, '0, key_at(5, '0, 5, 0), 1, outcome(1, 0, 0, 0, 0, 0, 0)));
        plan.push_back(make_row(0, '0, key_at(5, 5, '0, 0), 1, outcome(1, 0, 0, 0, 0, 0, 0)));
        plan.push_back(make_row(0, '0, key_at(1, 1, 1, 100), 1, outcome(0, 0, 0, 1, 1, 0, 0)));
        plan.push_back(make_row(0, '0, key_at(1, 1, 1, 200), 1, outcome(0, 1, 0, 1, 1, 1, 0)));
        plan.push_back(make_row(0, '0, key_at(WORD_TOP, WORD_TOP, WORD_TOP, 300), 1,
                                outcome(0, 0, 0, 2, 2, 1, 0)));
        plan.push_back(make_row(0, '0, key_at('0, '0, '0, 300), 1,
                                outcome(1, 0, 0, 2, 2, 1, 0)));
        plan.push_back(make_row(0, '0, key_at(WORD_TOP, WORD_TOP, WORD_TOP, 60300), 0, none));
        plan.push_back(make_row(0, '0, key_at(2, 3, 4, TIME_TOP), 0, none));
        plan.push_back(make_row(0, '0, key_at(2, 3, 4, TIME_TOP), 0, none));
        // zero retention rejects a well-formed key
        plan.push_back(make_row(1, '0, key_at(7, 7, 7, 1000), 0, none));
        plan.push_back(make_row(1, 32'd1, key_at(8, 8, 8, 1000), 0, none));
        plan.push_back(make_row(0, '0, key_at(8, 8, 8, 1000), 0, none));
        plan.push_back(make_row(0, '0, key_at(8, 8, 8, 1001), 0, none));
        // longest retention saturates the expiry
        plan.push_back(make_row(1, WORD_TOP, key_at(9, 9, 9, TIME_TOP - 5), 0, none));
        plan.push_back(make_row(0, '0, key_at(9, 9, 9, 0), 0, none));
        plan.push_back(make_row(0, '0, key_at(WORD_TOP, 1, 1, 5000), 0, none));
        plan.push_back(make_row(0, '0, key_at(1, WORD_TOP, 1, 5000), 0, none));
        plan.push_back(make_row(0, '0, key_at(1, 1, WORD_TOP, 5000), 0, none));
        plan.push_back(make_row(0, '0, key_at('0, '0, '0, TIME_TOP), 0, none));

        foreach (plan[i])
        begin
            if (plan[i].set_keep)
                set_retention(plan[i].keep);
            send_item(plan[i].it, plan[i].typed, plan[i].want);
            pause_sender(pick_gap());
        end

        // random phases over several retention settings
        phase_keep[0] = RETENTION_RESET; phase_len[0] = 160;
        phase_keep[1] = 32'd1;           phase_len[1] = 160;
        phase_keep[2] = WORD_TOP;        phase_len[2] = 160;
        phase_keep[3] = '0;              phase_len[3] = 40;
        phase_keep[4] = nonzero_word();  phase_len[4] = 160;
        phase_keep[5] = 32'd2500;        phase_len[5] = 160;

        for (int p = 0; p < 6; p++)
        begin
            set_retention(phase_keep[p]);
            foreach (alias_pool[i])
                alias_pool[i] = nonzero_word();
            foreach (epoch_pool[i])
                epoch_pool[i] = nonzero_word();
            foreach (msg_pool[i])
                msg_pool[i] = nonzero_word();
            case (p)
                0: clock_now = '0;
                2: clock_now = TIME_TOP - 64'd40_000_000_000;
                default: clock_now = {$urandom, $urandom};
            endcase
            for (int n = 0; n < phase_len[p]; n++)
            begin
                if (n % 50 == 0)
                    sender_calm = ($urandom_range(0, 3) == 0);
                if (n == phase_len[p] / 2)
                    drain_results();
                send_item(random_item(), 1'b0, none);
                pause_sender(pick_gap());
            end
        end

        drain_results();
        repeat (SETTLE_CYC) @(posedge clk);
        if (mismatches == 0 && outcome_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // Run limit
    initial
    begin
        #8_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ expiring_duplicate_filter_top.f @@
design/edf_pkg.sv
design/edf_slot_store.sv
design/edf_scan_unit.sv
design/expiring_duplicate_filter_top.sv
verif/expiring_duplicate_filter_top_test.sv
